// ===== src/hrhp_pkg.sv =====
package hrhp_pkg;

	// verdict codes
	typedef enum logic [1:0] {
		V_INCOMPLETE = 2'd0,
		V_COMPLETE   = 2'd1,
		V_ERROR      = 2'd2
	} verdict_t;

	// byte role codes
	typedef enum logic [2:0] {
		ROLE_NONE   = 3'd0,
		ROLE_METHOD = 3'd1,
		ROLE_URI    = 3'd2,
		ROLE_NAME   = 3'd3,
		ROLE_VALUE  = 3'd4
	} role_t;

	// grammar position, one-hot
	typedef enum logic [20:0] {
		PH_METHOD_START = 21'h000001,
		PH_METHOD       = 21'h000002,
		PH_URI_START    = 21'h000004,
		PH_URI          = 21'h000008,
		PH_VER_H        = 21'h000010,
		PH_VER_T1       = 21'h000020,
		PH_VER_T2       = 21'h000040,
		PH_VER_P        = 21'h000080,
		PH_VER_SLASH    = 21'h000100,
		PH_MAJOR_START  = 21'h000200,
		PH_MAJOR        = 21'h000400,
		PH_MINOR_START  = 21'h000800,
		PH_MINOR        = 21'h001000,
		PH_LF_1         = 21'h002000,
		PH_LINE_START   = 21'h004000,
		PH_LWS          = 21'h008000,
		PH_NAME         = 21'h010000,
		PH_SPACE_BEFORE = 21'h020000,
		PH_VALUE        = 21'h040000,
		PH_LF_2         = 21'h080000,
		PH_LF_3         = 21'h100000
	} phase_t;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CTL_MAX  = 8'h1F;
	localparam logic [7:0] VER_MAX  = 8'hFF;

	function automatic logic is_ctl(input logic [7:0] b);
		return (b <= CTL_MAX) || (b == CH_DEL);
	endfunction

	function automatic logic is_sep(input logic [7:0] b);
		return b inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
			8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09};
	endfunction

	function automatic logic is_token(input logic [7:0] b);
		return !b[7] && !is_ctl(b) && !is_sep(b);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// acc*10 + digit, saturating at 255
	function automatic logic [7:0] acc_digit(input logic [7:0] acc, input logic [7:0] b);
		logic [11:0] sum;
		sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, b[3:0]};
		return (sum > {4'd0, VER_MAX}) ? VER_MAX : sum[7:0];
	endfunction

endpackage

// ===== src/hrhp_if.sv =====
interface hrhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       restart;

	modport source (output valid, output rx_byte, output restart, input ready);
	modport sink (input valid, input rx_byte, input restart, output ready);
endinterface

interface hrhp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic [2:0] byte_role;
	logic       header_begin;
	logic [7:0] echo_byte;
	logic [7:0] version_major;
	logic [7:0] version_minor;

	modport source (output valid, output verdict, output byte_role, output header_begin,
		output echo_byte, output version_major, output version_minor, input ready);
	modport sink (input valid, input verdict, input byte_role, input header_begin,
		input echo_byte, input version_major, input version_minor, output ready);
endinterface

// ===== src/http_request_header_parser.sv =====
// HTTP/1.1 request line and header parser. Feed the request text one byte per item on req;
// every byte gives exactly one result item on res, in order, with a verdict (incomplete,
// complete, syntax error), the role of the byte (method, uri, header name, header value or
// none), a flag on the first byte of each header name, the byte itself, and the version
// numbers seen so far (saturating at 255). A syntax error leaves the parse position where it
// was, so the next byte is judged at the same place; restart on a byte starts a new request
// with that byte. The block takes one byte per clock cycle unless the result side stalls:
// a byte goes through an input register, the combinational grammar logic, and an output
// register, where its result can be taken. The grammar position lives in a one-hot phase
// register, beside the header-seen flag and the version numbers, all updated as each byte
// leaves the input register, which is what sets the rate. A stalled result side holds the
// output register, and the input register still takes one more byte if it is empty.
module http_request_header_parser (
	input logic       clk,
	input logic       arst_n,
	hrhp_in_if.sink   req,
	hrhp_out_if.source res
);

	// input stage
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       restart_s1;

	// output stage
	logic                valid_s2;
	hrhp_pkg::verdict_t  verdict_s2;
	hrhp_pkg::role_t     role_s2;
	logic                begin_s2;
	logic [7:0]          echo_s2;
	logic [7:0]          major_s2;
	logic [7:0]          minor_s2;

	// parse state
	hrhp_pkg::phase_t phase_q;
	logic             hdr_seen_q;
	logic [7:0]       major_q;
	logic [7:0]       minor_q;

	logic advance;
	logic take_in;

	// state seen by the current byte (after an optional restart)
	hrhp_pkg::phase_t phase_cur;
	logic             hdr_seen_cur;
	logic [7:0]       major_cur;
	logic [7:0]       minor_cur;

	// next values
	hrhp_pkg::phase_t   phase_nxt;
	logic               hdr_seen_nxt;
	logic [7:0]         major_nxt;
	logic [7:0]         minor_nxt;
	hrhp_pkg::verdict_t verdict_nxt;
	hrhp_pkg::role_t    role_nxt;
	logic               begin_nxt;
	logic               err;

	// handshake: output register frees when empty or taken
	assign advance   = !valid_s2 || res.ready;
	assign req.ready = !valid_s1 || advance;
	assign take_in   = req.valid && req.ready;

	always_comb begin
		phase_cur    = restart_s1 ? hrhp_pkg::PH_METHOD_START : phase_q;
		hdr_seen_cur = restart_s1 ? 1'b0 : hdr_seen_q;
		major_cur    = restart_s1 ? 8'd0 : major_q;
		minor_cur    = restart_s1 ? 8'd0 : minor_q;
	end

	// grammar step
	always_comb begin
		phase_nxt    = phase_cur;
		hdr_seen_nxt = hdr_seen_cur;
		major_nxt    = major_cur;
		minor_nxt    = minor_cur;
		verdict_nxt  = hrhp_pkg::V_INCOMPLETE;
		role_nxt     = hrhp_pkg::ROLE_NONE;
		begin_nxt    = 1'b0;
		err          = 1'b0;
		case (phase_cur)
			hrhp_pkg::PH_METHOD_START: begin
				if (hrhp_pkg::is_token(rx_byte_s1)) begin
					phase_nxt = hrhp_pkg::PH_METHOD;
					role_nxt  = hrhp_pkg::ROLE_METHOD;
				end else
					err = 1'b1;
			end
			hrhp_pkg::PH_METHOD: begin
				if (rx_byte_s1 == hrhp_pkg::CH_SPACE)
					phase_nxt = hrhp_pkg::PH_URI_START;
				else if (hrhp_pkg::is_token(rx_byte_s1))
					role_nxt = hrhp_pkg::ROLE_METHOD;
				else
					err = 1'b1;
			end
			hrhp_pkg::PH_URI_START: begin
				if (hrhp_pkg::is_ctl(rx_byte_s1) || rx_byte_s1 == hrhp_pkg::CH_SPACE)
					err = 1'b1;
				else begin
					phase_nxt = hrhp_pkg::PH_URI;
					role_nxt  = hrhp_pkg::ROLE_URI;
				end
			end
			hrhp_pkg::PH_URI: begin
				if (rx_byte_s1 == hrhp_pkg::CH_SPACE)
					phase_nxt = hrhp_pkg::PH_VER_H;
				else if (hrhp_pkg::is_ctl(rx_byte_s1))
					err = 1'b1;
				else
					role_nxt = hrhp_pkg::ROLE_URI;
			end
			hrhp_pkg::PH_VER_H: begin
				if (rx_byte_s1 == hrhp_pkg::CH_H) phase_nxt = hrhp_pkg::PH_VER_T1;
				else err = 1'b1;
			end
			hrhp_pkg::PH_VER_T1: begin
				if (rx_byte_s1 == hrhp_pkg::CH_T) phase_nxt = hrhp_pkg::PH_VER_T2;
				else err = 1'b1;
			end
			hrhp_pkg::PH_VER_T2: begin
				if (rx_byte_s1 == hrhp_pkg::CH_T) phase_nxt = hrhp_pkg::PH_VER_P;
				else err = 1'b1;
			end
			hrhp_pkg::PH_VER_P: begin
				if (rx_byte_s1 == hrhp_pkg::CH_P) phase_nxt = hrhp_pkg::PH_VER_SLASH;
				else err = 1'b1;
			end
			hrhp_pkg::PH_VER_SLASH: begin
				if (rx_byte_s1 == hrhp_pkg::CH_SLASH) begin
					major_nxt = 8'd0;
					minor_nxt = 8'd0;
					phase_nxt = hrhp_pkg::PH_MAJOR_START;
				end else
					err = 1'b1;
			end
			hrhp_pkg::PH_MAJOR_START: begin
				if (hrhp_pkg::is_digit(rx_byte_s1)) begin
					major_nxt = hrhp_pkg::acc_digit(major_cur, rx_byte_s1);
					phase_nxt = hrhp_pkg::PH_MAJOR;
				end else
					err = 1'b1;
			end
			hrhp_pkg::PH_MAJOR: begin
				if (rx_byte_s1 == hrhp_pkg::CH_DOT)
					phase_nxt = hrhp_pkg::PH_MINOR_START;
				else if (hrhp_pkg::is_digit(rx_byte_s1))
					major_nxt = hrhp_pkg::acc_digit(major_cur, rx_byte_s1);
				else
					err = 1'b1;
			end
			hrhp_pkg::PH_MINOR_START: begin
				if (hrhp_pkg::is_digit(rx_byte_s1)) begin
					minor_nxt = hrhp_pkg::acc_digit(minor_cur, rx_byte_s1);
					phase_nxt = hrhp_pkg::PH_MINOR;
				end else
					err = 1'b1;
			end
			hrhp_pkg::PH_MINOR: begin
				if (rx_byte_s1 == hrhp_pkg::CH_CR)
					phase_nxt = hrhp_pkg::PH_LF_1;
				else if (hrhp_pkg::is_digit(rx_byte_s1))
					minor_nxt = hrhp_pkg::acc_digit(minor_cur, rx_byte_s1);
				else
					err = 1'b1;
			end
			hrhp_pkg::PH_LF_1: begin
				if (rx_byte_s1 == hrhp_pkg::CH_LF) phase_nxt = hrhp_pkg::PH_LINE_START;
				else err = 1'b1;
			end
			hrhp_pkg::PH_LINE_START: begin
				if (rx_byte_s1 == hrhp_pkg::CH_CR)
					phase_nxt = hrhp_pkg::PH_LF_3;
				else if (hdr_seen_cur && (rx_byte_s1 == hrhp_pkg::CH_SPACE
						|| rx_byte_s1 == hrhp_pkg::CH_TAB))
					phase_nxt = hrhp_pkg::PH_LWS;
				else if (hrhp_pkg::is_token(rx_byte_s1)) begin
					hdr_seen_nxt = 1'b1;
					phase_nxt    = hrhp_pkg::PH_NAME;
					role_nxt     = hrhp_pkg::ROLE_NAME;
					begin_nxt    = 1'b1;
				end else
					err = 1'b1;
			end
			hrhp_pkg::PH_LWS: begin
				if (rx_byte_s1 == hrhp_pkg::CH_CR)
					phase_nxt = hrhp_pkg::PH_LF_2;
				else if (rx_byte_s1 == hrhp_pkg::CH_SPACE || rx_byte_s1 == hrhp_pkg::CH_TAB)
					phase_nxt = hrhp_pkg::PH_LWS;
				else if (hrhp_pkg::is_ctl(rx_byte_s1))
					err = 1'b1;
				else begin
					phase_nxt = hrhp_pkg::PH_VALUE;
					role_nxt  = hrhp_pkg::ROLE_VALUE;
				end
			end
			hrhp_pkg::PH_NAME: begin
				if (rx_byte_s1 == hrhp_pkg::CH_COLON)
					phase_nxt = hrhp_pkg::PH_SPACE_BEFORE;
				else if (hrhp_pkg::is_token(rx_byte_s1))
					role_nxt = hrhp_pkg::ROLE_NAME;
				else
					err = 1'b1;
			end
			hrhp_pkg::PH_SPACE_BEFORE: begin
				if (rx_byte_s1 == hrhp_pkg::CH_SPACE) phase_nxt = hrhp_pkg::PH_VALUE;
				else err = 1'b1;
			end
			hrhp_pkg::PH_VALUE: begin
				if (rx_byte_s1 == hrhp_pkg::CH_CR)
					phase_nxt = hrhp_pkg::PH_LF_2;
				else if (hrhp_pkg::is_ctl(rx_byte_s1))
					err = 1'b1;
				else
					role_nxt = hrhp_pkg::ROLE_VALUE;
			end
			hrhp_pkg::PH_LF_2: begin
				if (rx_byte_s1 == hrhp_pkg::CH_LF) phase_nxt = hrhp_pkg::PH_LINE_START;
				else err = 1'b1;
			end
			hrhp_pkg::PH_LF_3: begin
				// blank line seen: each further lf reports complete again
				if (rx_byte_s1 == hrhp_pkg::CH_LF) verdict_nxt = hrhp_pkg::V_COMPLETE;
				else err = 1'b1;
			end
			default: begin
				err = 1'b1;
			end
		endcase
		// a rejected byte changes nothing
		if (err) begin
			phase_nxt    = phase_cur;
			hdr_seen_nxt = hdr_seen_cur;
			major_nxt    = major_cur;
			minor_nxt    = minor_cur;
			verdict_nxt  = hrhp_pkg::V_ERROR;
			role_nxt     = hrhp_pkg::ROLE_NONE;
			begin_nxt    = 1'b0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			rx_byte_s1 <= req.rx_byte;
			restart_s1 <= req.restart;
		end
	end

	// parse state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			phase_q    <= hrhp_pkg::PH_METHOD_START;
			hdr_seen_q <= 1'b0;
			major_q    <= 8'd0;
			minor_q    <= 8'd0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				phase_q    <= phase_nxt;
				hdr_seen_q <= hdr_seen_nxt;
				major_q    <= major_nxt;
				minor_q    <= minor_nxt;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			verdict_s2 <= verdict_nxt;
			role_s2    <= role_nxt;
			begin_s2   <= begin_nxt;
			echo_s2    <= rx_byte_s1;
			major_s2   <= major_nxt;
			minor_s2   <= minor_nxt;
		end
	end

	assign res.valid         = valid_s2;
	assign res.verdict       = verdict_s2;
	assign res.byte_role     = role_s2;
	assign res.header_begin  = begin_s2;
	assign res.echo_byte     = echo_s2;
	assign res.version_major = major_s2;
	assign res.version_minor = minor_s2;

	// rejected bytes carry no role and open no header
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && verdict_s2 == hrhp_pkg::V_ERROR |-> role_s2 == hrhp_pkg::ROLE_NONE && !begin_s2)
		else $error("error result carries a role or header begin");

	// a header begin is a header name byte and marks a header as seen
	a_begin_name: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && begin_s2 |-> role_s2 == hrhp_pkg::ROLE_NAME && hdr_seen_q)
		else $error("header begin without header name state");

	// complete is only reported while waiting for the final lf
	a_complete_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && verdict_s2 == hrhp_pkg::V_COMPLETE |-> phase_q == hrhp_pkg::PH_LF_3)
		else $error("complete reported outside final lf phase");

	// no byte is taken while both stages are full and the output is stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !res.ready |-> !take_in)
		else $error("input item accepted with both stages full");

	// result payload holds under backpressure
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res.ready |=> valid_s2 && $stable(echo_s2) && $stable(verdict_s2))
		else $error("stalled result changed");

endmodule

// ===== dv/http_request_header_parser_tb.sv =====
`timescale 1ns / 100ps

module http_request_header_parser_tb;
	import hrhp_pkg::*;

	localparam int RANDOM_ITEMS = 1600;
	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 6;
	// two-stage pipe; the drain wait covers anything still in flight
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_LIMIT   = 1000;
	// long receiver hold-off, starts once this many results have been checked
	localparam int HOLD_CYCLES  = 100;
	localparam int HOLD_AFTER   = 400;

	// one byte of request text as offered on req
	typedef struct {
		logic [7:0] b;
		logic       restart;
	} text_item_t;

	// what the parser should answer for one byte
	typedef struct {
		verdict_t   verdict;
		role_t      role;
		logic       hdr_begin;
		logic [7:0] echo;
		logic [7:0] major;
		logic [7:0] minor;
	} byte_result_t;

	// receiver back-pressure styles
	typedef enum {
		RX_OPEN,
		RX_COIN,
		RX_RARE_STALL,
		RX_PERIODIC
	} rx_mode_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       drv_valid   = 1'b0;
	logic [7:0] drv_byte    = 8'h00;
	logic       drv_restart = 1'b0;
	logic       drv_ready   = 1'b0;

	hrhp_in_if  req_if();
	hrhp_out_if res_if();

	assign req_if.valid   = drv_valid;
	assign req_if.rx_byte = drv_byte;
	assign req_if.restart = drv_restart;
	assign res_if.ready   = drv_ready;

	http_request_header_parser uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.res   (res_if)
	);

	// request text still to be offered, front is the item on the bus
	text_item_t   request_text[$];
	// predicted answers for accepted bytes, oldest first
	byte_result_t parse_results_due[$];

	// parser state as the predictor sees it
	phase_t     cur_phase  = PH_METHOD_START;
	logic       hdr_opened = 1'b0;
	logic [7:0] maj_ver    = 8'h00;
	logic [7:0] min_ver    = 8'h00;

	bit restart_next = 1'b0;
	bit req_fire     = 1'b0;
	bit failed       = 1'b0;

	int bytes_checked  = 0;
	int mismatches     = 0;
	int requests_done  = 0;
	int bytes_rejected = 0;
	int names_opened   = 0;
	int idle_cycles    = 0;

	// sender burst state
	int burst_left = 16;
	int gap_left   = 0;

	// receiver state
	rx_mode_t rx_mode   = RX_OPEN;
	int       mode_left = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;
	int       rx_cycle  = 0;

	// character classes of the request grammar
	function automatic logic ctl_char(input logic [7:0] c);
		return (c < 8'd32) || (c == CH_DEL);
	endfunction

	function automatic logic sep_char(input logic [7:0] c);
		case (c)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
			"/", "[", "]", "?", "=", "{", "}", " ", "\t": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// bytes with the top bit set are never token characters
	function automatic logic token_char(input logic [7:0] c);
		return !c[7] && !ctl_char(c) && !sep_char(c);
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// decimal accumulate, pinned at the top value
	function automatic logic [7:0] ver_step(input logic [7:0] acc, input logic [7:0] c);
		int sum;
		sum = int'(acc) * 10 + int'(c - CH_ZERO);
		return (sum > int'(VER_MAX)) ? VER_MAX : sum[7:0];
	endfunction

	// advance the grammar by one byte and give the answer the block owes for it
	function automatic byte_result_t parse_byte(input logic [7:0] c, input logic restart);
		byte_result_t r;
		phase_t       nxt;
		logic         err;
		if (restart) begin
			cur_phase  = PH_METHOD_START;
			hdr_opened = 1'b0;
			maj_ver    = 8'h00;
			min_ver    = 8'h00;
		end
		nxt         = cur_phase;
		err         = 1'b0;
		r.verdict   = V_INCOMPLETE;
		r.role      = ROLE_NONE;
		r.hdr_begin = 1'b0;
		r.echo      = c;
		case (cur_phase)
			PH_METHOD_START: begin
				if (token_char(c)) begin
					nxt    = PH_METHOD;
					r.role = ROLE_METHOD;
				end else
					err = 1'b1;
			end
			PH_METHOD: begin
				if (c == CH_SPACE)
					nxt = PH_URI_START;
				else if (token_char(c))
					r.role = ROLE_METHOD;
				else
					err = 1'b1;
			end
			// first uri byte: an empty uri is rejected here
			PH_URI_START: begin
				if (ctl_char(c) || c == CH_SPACE)
					err = 1'b1;
				else begin
					nxt    = PH_URI;
					r.role = ROLE_URI;
				end
			end
			PH_URI: begin
				if (c == CH_SPACE)
					nxt = PH_VER_H;
				else if (ctl_char(c))
					err = 1'b1;
				else
					r.role = ROLE_URI;
			end
			PH_VER_H: begin
				if (c == CH_H) nxt = PH_VER_T1; else err = 1'b1;
			end
			PH_VER_T1: begin
				if (c == CH_T) nxt = PH_VER_T2; else err = 1'b1;
			end
			PH_VER_T2: begin
				if (c == CH_T) nxt = PH_VER_P; else err = 1'b1;
			end
			PH_VER_P: begin
				if (c == CH_P) nxt = PH_VER_SLASH; else err = 1'b1;
			end
			// the slash clears both version numbers
			PH_VER_SLASH: begin
				if (c == CH_SLASH) begin
					maj_ver = 8'h00;
					min_ver = 8'h00;
					nxt     = PH_MAJOR_START;
				end else
					err = 1'b1;
			end
			PH_MAJOR_START: begin
				if (digit_char(c)) begin
					maj_ver = ver_step(maj_ver, c);
					nxt     = PH_MAJOR;
				end else
					err = 1'b1;
			end
			PH_MAJOR: begin
				if (c == CH_DOT)
					nxt = PH_MINOR_START;
				else if (digit_char(c))
					maj_ver = ver_step(maj_ver, c);
				else
					err = 1'b1;
			end
			PH_MINOR_START: begin
				if (digit_char(c)) begin
					min_ver = ver_step(min_ver, c);
					nxt     = PH_MINOR;
				end else
					err = 1'b1;
			end
			PH_MINOR: begin
				if (c == CH_CR)
					nxt = PH_LF_1;
				else if (digit_char(c))
					min_ver = ver_step(min_ver, c);
				else
					err = 1'b1;
			end
			PH_LF_1: begin
				if (c == CH_LF) nxt = PH_LINE_START; else err = 1'b1;
			end
			// blank line, folded continuation or a new header name
			PH_LINE_START: begin
				if (c == CH_CR)
					nxt = PH_LF_3;
				else if (hdr_opened && (c == CH_SPACE || c == CH_TAB))
					nxt = PH_LWS;
				else if (token_char(c)) begin
					hdr_opened  = 1'b1;
					nxt         = PH_NAME;
					r.role      = ROLE_NAME;
					r.hdr_begin = 1'b1;
				end else
					err = 1'b1;
			end
			PH_LWS: begin
				if (c == CH_CR)
					nxt = PH_LF_2;
				else if (c == CH_SPACE || c == CH_TAB) begin
					// more folding whitespace
				end else if (ctl_char(c))
					err = 1'b1;
				else begin
					nxt    = PH_VALUE;
					r.role = ROLE_VALUE;
				end
			end
			PH_NAME: begin
				if (c == CH_COLON)
					nxt = PH_SPACE_BEFORE;
				else if (token_char(c))
					r.role = ROLE_NAME;
				else
					err = 1'b1;
			end
			PH_SPACE_BEFORE: begin
				if (c == CH_SPACE) nxt = PH_VALUE; else err = 1'b1;
			end
			PH_VALUE: begin
				if (c == CH_CR)
					nxt = PH_LF_2;
				else if (ctl_char(c))
					err = 1'b1;
				else
					r.role = ROLE_VALUE;
			end
			PH_LF_2: begin
				if (c == CH_LF) nxt = PH_LINE_START; else err = 1'b1;
			end
			// parked after the blank line: every lf completes again
			PH_LF_3: begin
				if (c == CH_LF) r.verdict = V_COMPLETE; else err = 1'b1;
			end
			default: err = 1'b1;
		endcase
		// a rejected byte leaves the grammar position alone
		if (err) begin
			r.verdict   = V_ERROR;
			r.role      = ROLE_NONE;
			r.hdr_begin = 1'b0;
		end else
			cur_phase = nxt;
		r.major = maj_ver;
		r.minor = min_ver;
		return r;
	endfunction

	// stimulus building

	task automatic put_byte(input logic [7:0] c);
		text_item_t it;
		it.b         = c;
		it.restart   = restart_next;
		restart_next = 1'b0;
		request_text.insert(request_text.size(), it);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_crlf();
		put_byte(CH_CR);
		put_byte(CH_LF);
	endtask

	function automatic logic [7:0] rand_token();
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 126));
		while (!token_char(c));
		return c;
	endfunction

	function automatic logic [7:0] rand_uri_char();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(33, 126));
	endfunction

	// values may hold spaces, but no control bytes
	function automatic logic [7:0] rand_value_char();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(32, 126));
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// one request with random content; some are broken on purpose
	task automatic put_request();
		int         start;
		int         nhdr;
		int         pos;
		text_item_t junk;
		start        = request_text.size();
		restart_next = ($urandom_range(0, 7) != 0);
		repeat ($urandom_range(1, 7)) put_byte(rand_token());
		put_byte(CH_SPACE);
		repeat ($urandom_range(1, 12)) put_byte(rand_uri_char());
		put_text(" HTTP/");
		repeat ($urandom_range(1, 4)) put_byte(rand_digit());
		put_byte(CH_DOT);
		repeat ($urandom_range(1, 4)) put_byte(rand_digit());
		put_crlf();
		nhdr = $urandom_range(0, 4);
		for (int h = 0; h < nhdr; h++) begin
			repeat ($urandom_range(1, 10)) put_byte(rand_token());
			put_text(": ");
			repeat ($urandom_range(0, 12)) put_byte(rand_value_char());
			put_crlf();
			// folded continuation of this header
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3))
					put_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
				repeat ($urandom_range(0, 8)) put_byte(rand_value_char());
				put_crlf();
			end
		end
		put_crlf();
		// trailing lf completes again, trailing junk is rejected
		case ($urandom_range(0, 7))
			0: put_byte(CH_LF);
			1: put_byte(8'($urandom_range(0, 255)));
			default: begin
			end
		endcase
		// damage: overwrite a byte, slip one in, or cut the tail off
		case ($urandom_range(0, 7))
			0: begin
				pos = $urandom_range(start, request_text.size() - 1);
				request_text[pos].b = 8'($urandom_range(0, 255));
			end
			1: begin
				pos          = $urandom_range(start, request_text.size() - 1);
				junk.b       = 8'($urandom_range(0, 255));
				junk.restart = 1'b0;
				request_text.insert(pos, junk);
			end
			2: begin
				repeat ($urandom_range(1, request_text.size() - start - 1))
					void'(request_text.pop_back());
			end
			default: begin
			end
		endcase
	endtask

	// raw random bytes, now and then with restart
	task automatic put_noise();
		repeat ($urandom_range(1, 16)) begin
			restart_next = ($urandom_range(0, 5) == 0);
			put_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
			failed = 1'b1;
		end
	endtask

	// clock
	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// driver: bursts of items with random gaps, holds an item until taken
	always @(negedge clk) begin
		if (!arst_n)
			drv_valid <= 1'b0;
		else begin
			if (req_fire) begin
				void'(request_text.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			if (!drv_valid || req_fire) begin
				if (gap_left > 0) begin
					gap_left--;
					drv_valid <= 1'b0;
				end else if (request_text.size() == 0)
					drv_valid <= 1'b0;
				else begin
					drv_valid   <= 1'b1;
					drv_byte    <= request_text[0].b;
					drv_restart <= request_text[0].restart;
				end
			end
		end
	end

	// receiver: changing stall styles plus one long hold-off to fill the pipe
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			drv_ready <= 1'b0;
		end else if (!hold_done && bytes_checked >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			drv_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end else
				mode_left--;
			case (rx_mode)
				RX_OPEN:       drv_ready <= 1'b1;
				RX_COIN:       drv_ready <= ($urandom_range(0, 1) != 0);
				RX_RARE_STALL: drv_ready <= ($urandom_range(0, 7) != 0);
				default:       drv_ready <= ((rx_cycle % 5) != 0);
			endcase
		end
		rx_cycle++;
	end

	// input side: every accepted byte is run through the predictor
	always @(posedge clk) begin
		req_fire <= arst_n && req_if.valid && req_if.ready;
		if (arst_n && req_if.valid && req_if.ready)
			parse_results_due.insert(parse_results_due.size(),
				parse_byte(req_if.rx_byte, req_if.restart));
	end

	// output side: compare each result item against the oldest prediction
	always @(posedge clk) begin : result_check
		byte_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (parse_results_due.size() == 0) begin
				$error("result item with no byte behind it, echo_byte %0d", res_if.echo_byte);
				failed = 1'b1;
			end else begin
				want = parse_results_due.pop_front();
				check_field("verdict", 8'(want.verdict), 8'(res_if.verdict));
				check_field("byte_role", 8'(want.role), 8'(res_if.byte_role));
				check_field("header_begin", 8'(want.hdr_begin), 8'(res_if.header_begin));
				check_field("echo_byte", want.echo, res_if.echo_byte);
				check_field("version_major", want.major, res_if.version_major);
				check_field("version_minor", want.minor, res_if.version_minor);
				if (want.verdict == V_COMPLETE) requests_done++;
				if (want.verdict == V_ERROR) bytes_rejected++;
				if (want.hdr_begin) names_opened++;
				bytes_checked++;
			end
		end
	end

	// watchdog on cycles where no item moves on either side
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", idle_cycles);
			$display("http_request_header_parser verification failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		int directed_len;

		// directed opening, one request walking the corner cases
		restart_next = 1'b1;
		put_byte(8'h00);           // control byte where the method should start
		put_text("G ");
		put_byte(CH_SPACE);        // empty uri
		put_byte(8'hFF);           // high byte is a legal uri byte
		put_text(" HTTP/999.0");   // major saturates at 255
		put_crlf();
		put_byte(CH_TAB);          // folding before any header
		put_crlf();                // blank line completes the request
		put_byte(CH_LF);           // parked: another lf completes again
		put_text("x");             // parked: anything else is rejected
		directed_len = request_text.size();

		// random requests, mostly well formed, with noise mixed in
		while (request_text.size() < directed_len + RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				put_noise();
			else
				put_request();
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_text.size() != 0 || parse_results_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d bytes checked: %0d requests completed, %0d bytes rejected, %0d headers",
			bytes_checked, requests_done, bytes_rejected, names_opened);
		$display("receiver held off %0d cycles once; %0d field mismatches",
			HOLD_CYCLES, mismatches);
		if (!failed)
			$display("http_request_header_parser verification clean");
		else
			$display("http_request_header_parser verification failed");
		$finish;
	end

endmodule
